/* hw/rtl/ptc_pkg.sv */
// shared types and constants of the pressure/temperature compensation block
// no dependencies; used by the channel interfaces, ptc_core and the top level
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

    // field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 32;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY_TEMP_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMP_COEFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_TEMPERATURE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_COEFF      = 3'd5;

    // temperature band limits in 0.01 C
    localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW = 19'sd1000;

    // first-order scaling shifts
    localparam int TEMP_SHIFT = 23;
    localparam int OFF_SHIFT  = 6;
    localparam int SENS_SHIFT = 7;

    // second-order gains and shifts
    localparam int TI_MID_GAIN   = 12;
    localparam int TI_COLD_GAIN  = 14;
    localparam int TI_SHIFT      = 35;
    localparam int OFFI_MID_GAIN = 30;
    localparam int OFFI_MID_SHIFT = 8;
    localparam int OFFI_COLD_GAIN = 35;
    localparam int OFFI_COLD_SHIFT = 3;
    localparam int SENSI_GAIN    = 63;
    localparam int SENSI_SHIFT   = 5;

    // final pressure scaling (truncating divisions)
    localparam int PROD_SHIFT = 21;
    localparam int PRES_SHIFT = 15;

    // pipeline depth of the datapath
    localparam int STAGES = 10;

    // calibration words
    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_coeff;
    } t_cal;

    // one raw sample pair
    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } t_sample;

    // one compensated result
    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_centideg;
        logic signed [PRES_W-1:0] pressure_value;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/ptc_sample_if.sv */
// valid/ready channel carrying one raw pressure and temperature conversion pair
// depends on ptc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ptc_sample_if;
    logic                        valid;
    logic                        ready;
    logic [ptc_pkg::RAW_W-1:0]   raw_pressure;
    logic [ptc_pkg::RAW_W-1:0]   raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ptc_result_if.sv */
// valid/ready channel carrying one compensated temperature and pressure result
// depends on ptc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ptc_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [ptc_pkg::TEMP_W-1:0]  temperature_centideg;
    logic signed [ptc_pkg::PRES_W-1:0]  pressure_value;

    modport source (output valid, output temperature_centideg, output pressure_value,
                    input ready);
    modport sink   (input valid, input temperature_centideg, input pressure_value,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/ptc_core.sv */
// ten-stage compensation datapath with a common advance enable
// depends on ptc_pkg for types and constants
`timescale 1ns / 1ps
`default_nettype none

module ptc_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire ptc_pkg::t_sample i_raw,
    input  wire ptc_pkg::t_cal    i_cal,
    output logic                  o_vld,
    output ptc_pkg::t_result      o_res
);

    typedef enum logic [1:0] {
        BAND_HOT,
        BAND_MID,
        BAND_COLD
    } t_band;

    // valid bits travel with the data
    logic [ptc_pkg::STAGES-1:0] r_vld;

    // stage 1: dt
    logic signed [24:0] n_dt_s1, r_dt_s1;
    logic [23:0]        r_d1_s1;

    // stage 2: first-order products and dt squared
    logic signed [41:0] n_pt_s2, r_pt_s2;
    logic signed [41:0] n_poff_s2, r_poff_s2;
    logic signed [41:0] n_psens_s2, r_psens_s2;
    logic signed [49:0] dtsq_full;
    logic [47:0]        n_dtsq_s2, r_dtsq_s2;
    logic [23:0]        r_d1_s2;

    // stage 3: temperature delta, offset, sensitivity, candidate ti terms
    logic signed [41:0] pt_sh, poff_sh, psens_sh;
    logic [51:0]        ti_mid_full, ti_cold_full;
    logic signed [18:0] n_diff_s3, r_diff_s3;
    logic signed [35:0] n_off_s3, r_off_s3;
    logic signed [34:0] n_sens_s3, r_sens_s3;
    logic [16:0]        n_ti_mid_s3, r_ti_mid_s3;
    logic [16:0]        n_ti_cold_s3, r_ti_cold_s3;
    logic [23:0]        r_d1_s3;

    // stage 4: band, squared delta, first-order temperature
    logic signed [37:0] dsq_full;
    logic [33:0]        n_dsq_s4, r_dsq_s4;
    logic signed [18:0] n_temp_s4, r_temp_s4;
    t_band              n_band_s4, r_band_s4;
    logic [16:0]        n_ti_s4, r_ti_s4;
    logic signed [35:0] r_off_s4;
    logic signed [34:0] r_sens_s4;
    logic [23:0]        r_d1_s4;

    // stage 5: second-order offset and sensitivity terms
    logic [39:0]        offi_mid_full, offi_cold_full, sensi_full;
    logic [36:0]        n_offi_s5, r_offi_s5;
    logic [34:0]        n_sensi_s5, r_sensi_s5;
    logic signed [18:0] n_temp_s5, r_temp_s5;
    logic signed [35:0] r_off_s5;
    logic signed [34:0] r_sens_s5;
    logic [23:0]        r_d1_s5;

    // stage 6: corrected offset and sensitivity
    logic signed [37:0] n_off_s6, r_off_s6;
    logic signed [36:0] n_sens_s6, r_sens_s6;
    logic signed [18:0] r_temp_s6;
    logic [23:0]        r_d1_s6;

    // stage 7: split sensitivity times pressure
    logic [43:0]        n_pp_lo_s7, r_pp_lo_s7;
    logic signed [41:0] n_pp_hi_s7, r_pp_hi_s7;
    logic signed [37:0] r_off_s7;
    logic signed [18:0] r_temp_s7;

    // stage 8: full product
    logic signed [61:0] n_prod_s8, r_prod_s8;
    logic signed [37:0] r_off_s8;
    logic signed [18:0] r_temp_s8;

    // stage 9: product over 2^21, toward zero
    logic [61:0]        prod_bias;
    logic signed [61:0] prod_q;
    logic signed [40:0] n_q_s9, r_q_s9;
    logic signed [37:0] r_off_s9;
    logic signed [18:0] r_temp_s9;

    // stage 10: subtract offset, divide by 2^15 toward zero
    logic signed [41:0] pres_diff;
    logic [41:0]        pres_bias;
    logic signed [41:0] pres_q;
    logic signed [31:0] n_pres_s10, r_pres_s10;
    logic signed [18:0] r_temp_s10;

    // stage 1 logic
    assign n_dt_s1 = $signed({1'b0, i_raw.raw_temperature})
                   - $signed({1'b0, i_cal.reference_temperature, 8'h00});

    // stage 2 logic
    assign n_pt_s2    = 42'(r_dt_s1) * 42'($signed({1'b0, i_cal.temperature_coeff}));
    assign n_poff_s2  = 42'(r_dt_s1) * 42'($signed({1'b0, i_cal.offset_temp_coeff}));
    assign n_psens_s2 = 42'(r_dt_s1) * 42'($signed({1'b0, i_cal.sensitivity_temp_coeff}));
    assign dtsq_full  = 50'(r_dt_s1) * 50'(r_dt_s1);
    assign n_dtsq_s2  = dtsq_full[47:0];

    // stage 3 logic: arithmetic shifts give floor
    assign pt_sh    = r_pt_s2 >>> ptc_pkg::TEMP_SHIFT;
    assign poff_sh  = r_poff_s2 >>> ptc_pkg::OFF_SHIFT;
    assign psens_sh = r_psens_s2 >>> ptc_pkg::SENS_SHIFT;
    assign n_diff_s3 = $signed(pt_sh[18:0]);
    assign n_off_s3  = $signed({3'b000, i_cal.pressure_offset, 17'h00000})
                     + $signed(poff_sh[35:0]);
    assign n_sens_s3 = $signed({3'b000, i_cal.pressure_sensitivity, 16'h0000})
                     + $signed(psens_sh[34:0]);
    assign ti_mid_full  = 52'(r_dtsq_s2) * 52'(ptc_pkg::TI_MID_GAIN);
    assign ti_cold_full = 52'(r_dtsq_s2) * 52'(ptc_pkg::TI_COLD_GAIN);
    assign n_ti_mid_s3  = ti_mid_full[51:ptc_pkg::TI_SHIFT];
    assign n_ti_cold_s3 = ti_cold_full[51:ptc_pkg::TI_SHIFT];

    // stage 4 logic: bands compared on the delta from the reference
    assign dsq_full  = 38'(r_diff_s3) * 38'(r_diff_s3);
    assign n_dsq_s4  = dsq_full[33:0];
    assign n_temp_s4 = r_diff_s3 + ptc_pkg::TEMP_REF;

    always_comb begin
        if (r_diff_s3 > 19'sd0) begin
            n_band_s4 = BAND_HOT;
        end else if (r_diff_s3 > (ptc_pkg::TEMP_LOW - ptc_pkg::TEMP_REF)) begin
            n_band_s4 = BAND_MID;
        end else begin
            n_band_s4 = BAND_COLD;
        end
    end

    always_comb begin
        case (n_band_s4)
            BAND_MID:  n_ti_s4 = r_ti_mid_s3;
            BAND_COLD: n_ti_s4 = r_ti_cold_s3;
            default:   n_ti_s4 = '0;
        endcase
    end

    // stage 5 logic
    assign offi_mid_full  = (40'(r_dsq_s4) * 40'(ptc_pkg::OFFI_MID_GAIN))
                          >> ptc_pkg::OFFI_MID_SHIFT;
    assign offi_cold_full = (40'(r_dsq_s4) * 40'(ptc_pkg::OFFI_COLD_GAIN))
                          >> ptc_pkg::OFFI_COLD_SHIFT;
    assign sensi_full     = (40'(r_dsq_s4) * 40'(ptc_pkg::SENSI_GAIN))
                          >> ptc_pkg::SENSI_SHIFT;
    assign n_temp_s5 = r_temp_s4 - $signed({2'b00, r_ti_s4});

    always_comb begin
        case (r_band_s4)
            BAND_MID: begin
                n_offi_s5  = offi_mid_full[36:0];
                n_sensi_s5 = '0;
            end
            BAND_COLD: begin
                n_offi_s5  = offi_cold_full[36:0];
                n_sensi_s5 = sensi_full[34:0];
            end
            default: begin
                n_offi_s5  = '0;
                n_sensi_s5 = '0;
            end
        endcase
    end

    // stage 6 logic
    assign n_off_s6  = 38'(r_off_s5) - $signed({1'b0, r_offi_s5});
    assign n_sens_s6 = 37'(r_sens_s5) - $signed({2'b00, r_sensi_s5});

    // stage 7 logic: low 20 bits unsigned, upper 17 bits signed
    assign n_pp_lo_s7 = 44'(r_sens_s6[19:0]) * 44'(r_d1_s6);
    assign n_pp_hi_s7 = 42'($signed(r_sens_s6[36:20])) * 42'($signed({1'b0, r_d1_s6}));

    // stage 8 logic
    assign n_prod_s8 = (62'(r_pp_hi_s7) <<< 20) + $signed({18'h00000, r_pp_lo_s7});

    // stage 9 logic: bias negative values so the shift truncates toward zero
    assign prod_bias = r_prod_s8[61] ? 62'((64'd1 << ptc_pkg::PROD_SHIFT) - 64'd1) : '0;
    assign prod_q    = (r_prod_s8 + $signed(prod_bias)) >>> ptc_pkg::PROD_SHIFT;
    assign n_q_s9    = prod_q[40:0];

    // stage 10 logic
    assign pres_diff  = 42'(r_q_s9) - 42'(r_off_s9);
    assign pres_bias  = pres_diff[41] ? 42'((64'd1 << ptc_pkg::PRES_SHIFT) - 64'd1) : '0;
    assign pres_q     = (pres_diff + $signed(pres_bias)) >>> ptc_pkg::PRES_SHIFT;
    assign n_pres_s10 = pres_q[31:0];

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ptc_pkg::STAGES-2:0], i_vld};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dt_s1      <= n_dt_s1;
            r_d1_s1      <= i_raw.raw_pressure;

            r_pt_s2      <= n_pt_s2;
            r_poff_s2    <= n_poff_s2;
            r_psens_s2   <= n_psens_s2;
            r_dtsq_s2    <= n_dtsq_s2;
            r_d1_s2      <= r_d1_s1;

            r_diff_s3    <= n_diff_s3;
            r_off_s3     <= n_off_s3;
            r_sens_s3    <= n_sens_s3;
            r_ti_mid_s3  <= n_ti_mid_s3;
            r_ti_cold_s3 <= n_ti_cold_s3;
            r_d1_s3      <= r_d1_s2;

            r_dsq_s4     <= n_dsq_s4;
            r_temp_s4    <= n_temp_s4;
            r_band_s4    <= n_band_s4;
            r_ti_s4      <= n_ti_s4;
            r_off_s4     <= r_off_s3;
            r_sens_s4    <= r_sens_s3;
            r_d1_s4      <= r_d1_s3;

            r_offi_s5    <= n_offi_s5;
            r_sensi_s5   <= n_sensi_s5;
            r_temp_s5    <= n_temp_s5;
            r_off_s5     <= r_off_s4;
            r_sens_s5    <= r_sens_s4;
            r_d1_s5      <= r_d1_s4;

            r_off_s6     <= n_off_s6;
            r_sens_s6    <= n_sens_s6;
            r_temp_s6    <= r_temp_s5;
            r_d1_s6      <= r_d1_s5;

            r_pp_lo_s7   <= n_pp_lo_s7;
            r_pp_hi_s7   <= n_pp_hi_s7;
            r_off_s7     <= r_off_s6;
            r_temp_s7    <= r_temp_s6;

            r_prod_s8    <= n_prod_s8;
            r_off_s8     <= r_off_s7;
            r_temp_s8    <= r_temp_s7;

            r_q_s9       <= n_q_s9;
            r_off_s9     <= r_off_s8;
            r_temp_s9    <= r_temp_s8;

            r_pres_s10   <= n_pres_s10;
            r_temp_s10   <= r_temp_s9;
        end
    end

    assign o_vld                      = r_vld[ptc_pkg::STAGES-1];
    assign o_res.temperature_centideg = r_temp_s10;
    assign o_res.pressure_value       = r_pres_s10;

endmodule

`default_nettype wire

/* hw/rtl/pressure_temperature_compensation_top.sv */
// top level: calibration registers, compensation pipeline and output buffer
// depends on ptc_pkg, ptc_sample_if, ptc_result_if and ptc_core
//
// Usage:
//   i_sample carries one raw pressure and one raw temperature conversion per
//   transfer; o_result returns one compensated temperature (0.01 C) and one
//   compensated pressure per sample, in the order the samples arrived.
//   The six calibration words are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data; indexes 6 and 7 are ignored. The user must write them only
//   while no sample is in flight; the block itself does not enforce this.
//   Throughput: one sample per cycle while the skid entry is free, through
//   a ten-stage datapath followed by the output register ahead of o_result.
//   A result waiting at the output does not block new samples: an output
//   register plus one skid entry decouple the sink from the pipeline. Only
//   when the skid entry is full does i_sample.ready drop and the whole
//   pipeline hold; nothing in flight is dropped or duplicated.
//   Reset (synchronous, active low) empties the pipeline and the output
//   buffer and clears all calibration words to zero.
`timescale 1ns / 1ps
`default_nettype none

module pressure_temperature_compensation_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ptc_sample_if.sink                          i_sample,
    ptc_result_if.source                        o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ptc_pkg::CAL_W-1:0]      i_cfg_data
);

    ptc_pkg::t_cal    r_cal, n_cal;
    ptc_pkg::t_sample raw;
    ptc_pkg::t_result core_res;
    logic             core_vld;
    logic             pipe_en;
    logic             capture;
    logic             out_take;

    logic             r_out_vld, n_out_vld;
    logic             r_skid_vld, n_skid_vld;
    ptc_pkg::t_result r_out, n_out;
    ptc_pkg::t_result r_skid, n_skid;

    // calibration register writes
    always_comb begin
        n_cal = r_cal;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptc_pkg::CFG_PRESSURE_SENSITIVITY:   n_cal.pressure_sensitivity   = i_cfg_data;
                ptc_pkg::CFG_PRESSURE_OFFSET:        n_cal.pressure_offset        = i_cfg_data;
                ptc_pkg::CFG_SENSITIVITY_TEMP_COEFF: n_cal.sensitivity_temp_coeff = i_cfg_data;
                ptc_pkg::CFG_OFFSET_TEMP_COEFF:      n_cal.offset_temp_coeff      = i_cfg_data;
                ptc_pkg::CFG_REFERENCE_TEMPERATURE:  n_cal.reference_temperature  = i_cfg_data;
                ptc_pkg::CFG_TEMPERATURE_COEFF:      n_cal.temperature_coeff      = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    // pipeline advances while the skid entry is free
    assign pipe_en          = !r_skid_vld;
    assign i_sample.ready   = pipe_en;
    assign raw.raw_pressure    = i_sample.raw_pressure;
    assign raw.raw_temperature = i_sample.raw_temperature;

    ptc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (i_sample.valid),
        .i_raw   (raw),
        .i_cal   (r_cal),
        .o_vld   (core_vld),
        .o_res   (core_res)
    );

    // output register and skid entry
    assign capture  = pipe_en && core_vld;
    assign out_take = r_out_vld && o_result.ready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (out_take || !r_out_vld) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else if (capture) begin
                n_out     = core_res;
                n_out_vld = 1'b1;
            end else begin
                n_out_vld = 1'b0;
            end
        end else if (capture) begin
            n_skid     = core_res;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_result.valid                = r_out_vld;
    assign o_result.temperature_centideg = r_out.temperature_centideg;
    assign o_result.pressure_value       = r_out.pressure_value;

    // skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid while output register empty");

    // a result leaving the pipeline into a stalled output lands in the skid entry
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (capture && r_out_vld && !o_result.ready) |=> r_skid_vld)
        else $error("result from pipeline lost during output stall");

    // output valid only drops after a transfer
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_vld) |-> $past(o_result.ready))
        else $error("output result dropped without a transfer");

endmodule

`default_nettype wire

/* tb/tb_pressure_temperature_compensation_top.sv */
// self-checking testbench for pressure_temperature_compensation_top
// depends on ptc_pkg, ptc_sample_if, ptc_result_if and the top level rtl
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation_top;
    import ptc_pkg::*;

    localparam int IDLE_PCT     = 22;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = STAGES + 4;
    localparam int MAX_REPORTS  = 10;
    localparam int STEADY_FROM  = 300;
    localparam int STEADY_TO    = 450;

    // indexes outside the register map, writes are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    // band limits in 0.01 C
    localparam longint BAND_WARM = 2000;
    localparam longint BAND_COLD = 1000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CAL_W-1:0]     i_cfg_data;

    ptc_sample_if sample_ch ();
    ptc_result_if result_ch ();

    pressure_temperature_compensation_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_cal    cal_model;
    t_sample sample_q[$];
    t_result compensated_q[$];
    int      accepted_samples = 0;
    int      checked_results = 0;
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    logic    steady;

    // stretch with no idling on either side
    assign steady = (accepted_samples >= STEADY_FROM) && (accepted_samples < STEADY_TO);

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // first-order compensation plus three-band second-order correction
    function automatic t_result compensate(t_cal c, logic [RAW_W-1:0] rp,
                                           logic [RAW_W-1:0] rt);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, dt_sq, diff, diff_sq, ti, offi, sensi, pres;
        t_result r;
        d1 = rp;
        d2 = rt;
        c1 = c.pressure_sensitivity;
        c2 = c.pressure_offset;
        c3 = c.sensitivity_temp_coeff;
        c4 = c.offset_temp_coeff;
        c5 = c.reference_temperature;
        c6 = c.temperature_coeff;
        // arithmetic shifts of signed terms floor toward minus infinity
        dt   = d2 - (c5 <<< 8);
        temp = ((dt * c6) >>> 23) + BAND_WARM;
        off  = (c2 <<< 17) + ((c4 * dt) >>> 6);
        sens = (c1 <<< 16) + ((c3 * dt) >>> 7);
        dt_sq   = dt * dt;
        diff    = temp - BAND_WARM;
        diff_sq = diff * diff;
        ti = 0;
        offi = 0;
        sensi = 0;
        if (temp > BAND_WARM) begin
            ti = 0;
        end else if (temp > BAND_COLD) begin
            ti   = (12 * dt_sq) >>> 35;
            offi = (30 * diff_sq) / 256;
        end else begin
            ti    = (14 * dt_sq) >>> 35;
            offi  = (35 * diff_sq) / 8;
            sensi = (63 * diff_sq) / 32;
        end
        temp = temp - ti;
        off  = off - offi;
        sens = sens - sensi;
        // divisions truncate toward zero, result wraps to 32 bits
        pres = ((sens * d1) / 2097152 - off) / 32768;
        r.temperature_centideg = temp[TEMP_W-1:0];
        r.pressure_value       = pres[PRES_W-1:0];
        return r;
    endfunction

    function automatic logic [RAW_W-1:0] clamp_raw(longint v);
        if (v < 0) return '0;
        if (v > 64'h00FF_FFFF) return '1;
        return v[RAW_W-1:0];
    endfunction

    // raw temperature: full range or clustered around the reference point
    function automatic logic [RAW_W-1:0] pick_raw_temperature();
        longint center;
        longint offset;
        if ($urandom_range(2) == 0) return RAW_W'($urandom);
        center = cal_model.reference_temperature;
        center = center <<< 8;
        offset = $urandom_range(32'd1 << $urandom_range(23));
        if ($urandom_range(1) == 1) offset = -offset;
        return clamp_raw(center + offset);
    endfunction

    function automatic void queue_sample(logic [RAW_W-1:0] rp, logic [RAW_W-1:0] rt);
        t_sample s;
        s.raw_pressure    = rp;
        s.raw_temperature = rt;
        sample_q.push_back(s);
    endfunction

    task automatic queue_random(int count);
        repeat (count) queue_sample(RAW_W'($urandom), pick_raw_temperature());
    endtask

    // block until nothing is pending or in flight
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || sample_ch.valid || compensated_q.size() != 0);
    endtask

    // write all six calibration words plus the two unmapped indexes
    task automatic load_calibration(t_cal c);
        logic [CFG_IDX_W-1:0] idx [8];
        logic [CAL_W-1:0]     val [8];
        idx = '{CFG_PRESSURE_SENSITIVITY, CFG_UNUSED_LO, CFG_PRESSURE_OFFSET,
                CFG_SENSITIVITY_TEMP_COEFF, CFG_OFFSET_TEMP_COEFF, CFG_UNUSED_HI,
                CFG_REFERENCE_TEMPERATURE, CFG_TEMPERATURE_COEFF};
        val = '{c.pressure_sensitivity, CAL_W'($urandom), c.pressure_offset,
                c.sensitivity_temp_coeff, c.offset_temp_coeff, CAL_W'($urandom),
                c.reference_temperature, c.temperature_coeff};
        foreach (idx[k]) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            case (idx[k])
                CFG_PRESSURE_SENSITIVITY:   cal_model.pressure_sensitivity   = val[k];
                CFG_PRESSURE_OFFSET:        cal_model.pressure_offset        = val[k];
                CFG_SENSITIVITY_TEMP_COEFF: cal_model.sensitivity_temp_coeff = val[k];
                CFG_OFFSET_TEMP_COEFF:      cal_model.offset_temp_coeff      = val[k];
                CFG_REFERENCE_TEMPERATURE:  cal_model.reference_temperature  = val[k];
                CFG_TEMPERATURE_COEFF:      cal_model.temperature_coeff      = val[k];
                default: ;
            endcase
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS) $display("%s", msg);
        mismatch_count++;
    endtask

    // sample driver: predicts on each transfer, then offers the next item
    always @(posedge i_clk) begin : drive
        t_sample item;
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                compensated_q.push_back(compensate(cal_model, sample_ch.raw_pressure,
                                                   sample_ch.raw_temperature));
                accepted_samples++;
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (sample_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    item = sample_q.pop_front();
                    sample_ch.valid           <= 1'b1;
                    sample_ch.raw_pressure    <= item.raw_pressure;
                    sample_ch.raw_temperature <= item.raw_temperature;
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each transfer with the oldest prediction
    always @(posedge i_clk) begin : check
        t_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (compensated_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing pending: temp %0d pres %0d",
                        checked_results, result_ch.temperature_centideg,
                        result_ch.pressure_value));
                end else begin
                    want = compensated_q.pop_front();
                    if (result_ch.temperature_centideg !== want.temperature_centideg)
                        report_mismatch($sformatf("result %0d temperature: exp %0d got %0d",
                            checked_results, want.temperature_centideg,
                            result_ch.temperature_centideg));
                    if (result_ch.pressure_value !== want.pressure_value)
                        report_mismatch($sformatf("result %0d pressure: exp %0d got %0d",
                            checked_results, want.pressure_value, result_ch.pressure_value));
                end
                checked_results++;
            end
            result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[pressure_temperature_compensation_top] ERROR");
                $finish;
            end
        end
    end

    // stimulus phases
    initial begin : stimulus
        t_cal   typical;
        t_cal   rnd;
        longint band_edges [5];
        longint center, c6, n, dt;
        i_rst_n                   = 1'b0;
        i_cfg_we                  = 1'b0;
        i_cfg_idx                 = CFG_PRESSURE_SENSITIVITY;
        i_cfg_data                = '0;
        sample_ch.valid           = 1'b0;
        sample_ch.raw_pressure    = '0;
        sample_ch.raw_temperature = '0;
        result_ch.ready           = 1'b0;
        cal_model                 = '0;
        band_edges = '{2001, 2000, 1001, 1000, 999};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // calibration at reset value: field extremes and the mid-scale point
        queue_sample(24'h000000, 24'h000000);
        queue_sample(24'hFFFFFF, 24'hFFFFFF);
        queue_sample(24'hFFFFFF, 24'h000000);
        queue_sample(24'h000000, 24'hFFFFFF);
        queue_sample(24'h800000, 24'h7FFFFF);
        wait_drained();

        // datasheet-like calibration
        typical.pressure_sensitivity   = 16'd46372;
        typical.pressure_offset        = 16'd43981;
        typical.sensitivity_temp_coeff = 16'd29059;
        typical.offset_temp_coeff      = 16'd27842;
        typical.reference_temperature  = 16'd31553;
        typical.temperature_coeff      = 16'd28165;
        load_calibration(typical);

        // raw temperatures landing exactly on each side of the band limits
        center = typical.reference_temperature;
        center = center <<< 8;
        c6 = typical.temperature_coeff;
        foreach (band_edges[k]) begin
            n  = (band_edges[k] - BAND_WARM) <<< 23;
            dt = (n > 0) ? (n + c6 - 1) / c6 : n / c6;
            queue_sample(24'h000000, clamp_raw(center + dt));
            queue_sample(24'hFFFFFF, clamp_raw(center + dt));
        end
        queue_sample(24'h000000, 24'h000000);
        queue_sample(24'hFFFFFF, 24'h000000);
        queue_sample(24'hFFFFFF, 24'hFFFFFF);
        queue_sample(24'h000000, 24'hFFFFFF);
        queue_random(150);
        // sender holds until every result is out
        wait_drained();
        queue_random(150);
        wait_drained();

        // full-scale calibration
        load_calibration('1);
        queue_random(200);
        wait_drained();

        // random calibrations
        repeat (3) begin
            rnd = {$urandom, $urandom, $urandom};
            load_calibration(rnd);
            queue_random(170);
            wait_drained();
        end

        // all words written back to zero
        load_calibration('0);
        queue_random(100);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && compensated_q.size() == 0)
            $display("[pressure_temperature_compensation_top] OK");
        else
            $display("[pressure_temperature_compensation_top] ERROR");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_sample_if.sv
hw/rtl/ptc_result_if.sv
hw/rtl/ptc_core.sv
hw/rtl/pressure_temperature_compensation_top.sv
tb/tb_pressure_temperature_compensation_top.sv
